// File: sv/scfl_pkg.sv
// Package for the size-class free-list allocator.
// Holds field widths, status and kind codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package scfl_pkg;

    localparam int SIZE_W    = 13;
    localparam int OFF_W     = 16;
    localparam int GRAN_W    = 12;
    localparam int LINK_W    = GRAN_W + 1;
    localparam int GRAN_SH   = 4;
    localparam int CLS_SH    = 5;
    localparam int HDR_BYTES = 16;
    localparam int MIN_BYTES = 16;
    localparam int CLS_RAW_W = 9;
    localparam int NEED_W    = 14;
    localparam int SUM_W     = 18;
    localparam int BUMP_W    = 17;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_BADSIZE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic take;
        logic out_ld;
        logic free_wr;
        logic link_rd;
        logic pop_wr;
        logic bump_wr;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic is_free;
        logic head_vld;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/scfl_ctrl.sv
// Controller state machine of the size-class free-list allocator.
// Sequences head reads, link accesses and result loads. Depends on scfl_pkg.
`default_nettype none

module scfl_ctrl
    import scfl_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HEAD = 3'b010,
        S_LINK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_rst_n && i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                    if (i_sts.bad) begin
                        n_state = S_IDLE;
                    end else if (i_sts.is_free) begin
                        o_cmd.free_wr = 1'b1;
                    end else if (i_sts.head_vld) begin
                        o_cmd.link_rd = 1'b1;
                        n_state       = S_LINK;
                    end else begin
                        o_cmd.bump_wr = 1'b1;
                    end
                end
            end
            S_LINK: begin
                o_cmd.pop_wr = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/scfl_dp.sv
// Datapath of the size-class free-list allocator.
// Holds the class-head and link memories, the bump pointer and the output register.
// Depends on scfl_pkg.
`default_nettype none

module scfl_dp
    import scfl_pkg::*;
#(
    parameter int NUM_CLASSES = 254,
    parameter int MAX_SIZE    = 8096,
    parameter int POOL_LIMIT  = 65536
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  wire               i_kind,
    input  wire  [SIZE_W-1:0] i_size,
    input  wire  [OFF_W-1:0]  i_offset,
    input  wire               i_m_tready,
    output logic              o_m_tvalid,
    output logic [OFF_W-1:0]  o_user,
    output logic [1:0]        o_status
);

    localparam int CLS_W = $clog2(NUM_CLASSES);
    localparam int LINK_DEPTH = 1 << GRAN_W;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(POOL_LIMIT);

    logic [GRAN_W-1:0] heads_mem [NUM_CLASSES];
    logic [LINK_W-1:0] link_mem  [LINK_DEPTH];
    logic [NUM_CLASSES-1:0] r_vld;

    logic              r_kind;
    logic              r_bad;
    logic [CLS_W-1:0]  r_cls;
    logic [GRAN_W-1:0] r_gran_in;
    logic [GRAN_W-1:0] r_head_gran;
    logic              r_head_vld;
    logic [LINK_W-1:0] r_link;
    logic [BUMP_W-1:0] r_bump;
    logic              r_out_vld;
    logic [OFF_W-1:0]  r_out_user;
    logic [1:0]        r_out_st;

    logic [NEED_W-1:0]    w_round;
    logic [CLS_RAW_W-1:0] w_cls_raw;
    logic                 w_bad;
    logic [CLS_W-1:0]     w_cls;
    logic [NEED_W-1:0]    w_need;
    logic [SUM_W-1:0]     w_sum;
    logic                 w_oom;
    logic [OFF_W-1:0]     w_res_user;
    logic [1:0]           w_res_st;
    logic                 w_head_we;
    logic [GRAN_W-1:0]    w_head_wd;

    assign w_round   = {1'b0, i_size} + NEED_W'(31);
    assign w_cls_raw = (i_size <= SIZE_W'(MIN_BYTES)) ? '0 : w_round[NEED_W-1:CLS_SH];
    assign w_bad     = (i_size == '0) || (i_size > SIZE_W'(MAX_SIZE))
                    || (w_cls_raw >= CLS_RAW_W'(NUM_CLASSES));
    assign w_cls     = w_cls_raw[CLS_W-1:0];

    assign w_need = (r_cls == '0) ? NEED_W'(HDR_BYTES + MIN_BYTES)
                                  : NEED_W'(HDR_BYTES) + NEED_W'({r_cls, {CLS_SH{1'b0}}});
    assign w_sum  = SUM_W'(r_bump) + SUM_W'(w_need);
    assign w_oom  = w_sum > LIMIT;

    always_comb begin
        w_res_user = '0;
        w_res_st   = ST_OK;
        if (r_bad) begin
            w_res_st = ST_BADSIZE;
        end else if (r_kind == KIND_FREE) begin
            w_res_st = ST_OK;
        end else if (r_head_vld) begin
            w_res_user = {r_head_gran, {GRAN_SH{1'b0}}};
        end else if (w_oom) begin
            w_res_st = ST_OOM;
        end else begin
            w_res_user = r_bump[OFF_W-1:0] + OFF_W'(HDR_BYTES);
        end
    end

    assign w_head_we = i_cmd.free_wr || i_cmd.pop_wr;
    assign w_head_wd = i_cmd.free_wr ? r_gran_in : r_link[GRAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            heads_mem[r_cls] <= w_head_wd;
        end
        if (i_cmd.take && !w_bad) begin
            r_head_gran <= heads_mem[w_cls];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.free_wr) begin
            link_mem[r_gran_in] <= {r_head_vld, r_head_gran};
        end
        if (i_cmd.link_rd) begin
            r_link <= link_mem[r_head_gran];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind    <= i_kind;
            r_bad     <= w_bad;
            r_cls     <= w_cls;
            r_gran_in <= i_offset[OFF_W-1:GRAN_SH];
            if (!w_bad) begin
                r_head_vld <= r_vld[w_cls];
            end
        end
        if (i_cmd.out_ld) begin
            r_out_user <= w_res_user;
            r_out_st   <= w_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_bump    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.free_wr) begin
                r_vld[r_cls] <= 1'b1;
            end else if (i_cmd.pop_wr) begin
                r_vld[r_cls] <= r_link[GRAN_W];
            end
            if (i_cmd.bump_wr && !w_oom) begin
                r_bump <= w_sum[BUMP_W-1:0];
            end
            if (i_cmd.out_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.bad      = r_bad;
    assign o_sts.is_free  = (r_kind == KIND_FREE);
    assign o_sts.head_vld = r_head_vld;
    assign o_sts.out_free = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_user     = r_out_user;
    assign o_status   = r_out_st;

`ifndef SYNTHESIS
    a_bump_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_bump) <= LIMIT)
        else $error("bump pointer ran past the pool end");

    a_pop_after_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_wr |-> $past(i_cmd.link_rd))
        else $error("head update without a preceding link read");

    a_fail_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st != ST_OK) |-> (r_out_user == '0))
        else $error("failed request returned a nonzero offset");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> (r_out_vld && $stable(r_out_user)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// File: sv/size_class_free_list_allocator.sv
// The result of a request is loaded into the output register at the clock edge after
// its acceptance, once that register is free. A free, a bad size or an allocate served
// from the bump pointer passes the idle and head states; an allocate that pops a class
// list also passes the link state, because the class-head memory read is followed by a
// dependent read of the link memory before the new list head is written. A new request
// is accepted once the previous one has finished, while its result may still wait in the
// output register; a full output register holds the request in its head-read cycle.
// Class list heads have reset-cleared valid bits, so no clearing pass follows reset.
// Top level of the size-class free-list allocator; depends on scfl_pkg, scfl_ctrl
// and scfl_dp.
`default_nettype none

module size_class_free_list_allocator
    import scfl_pkg::*;
#(
    parameter int POOL_BYTES  = 65536,
    parameter int NUM_CLASSES = 254,
    parameter int MAX_SIZE    = 8096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,  // req_size[12:0], block_offset[28:13], zeros above
    input  wire  [0:0]  i_s_tuser,  // kind[0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,  // user_offset[15:0]
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    localparam int POOL_LIMIT = (POOL_BYTES < 65536) ? POOL_BYTES : 65536;

    t_cmd w_cmd;
    t_sts w_sts;

    scfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    scfl_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .MAX_SIZE    (MAX_SIZE),
        .POOL_LIMIT  (POOL_LIMIT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_kind     (i_s_tuser[0]),
        .i_size     (i_s_tdata[SIZE_W-1:0]),
        .i_offset   (i_s_tdata[SIZE_W+OFF_W-1:SIZE_W]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_user     (o_m_tdata),
        .o_status   (o_m_tuser)
    );

endmodule

`default_nettype wire

// File: tb/tb_size_class_free_list_allocator.sv
// Self-checking testbench for size_class_free_list_allocator: a directed opening,
// then random allocate/free traffic checked against a free-list predictor.
// Depends on scfl_pkg and the allocator RTL.
`default_nettype none

module tb_size_class_free_list_allocator;
    import scfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_BYTES  = 65536;
    localparam int NUM_CLASSES = 254;
    localparam int MAX_SIZE    = 8096;
    localparam int POOL_LIMIT  = (POOL_BYTES < 65536) ? POOL_BYTES : 65536;
    localparam int RANDOM_REQS = 600;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0] user;
        logic [1:0]       status;
    } t_reply;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_req   pending_reqs[$];
    t_reply expected_replies[$];
    t_block live_blocks[$];

    logic [LINK_W-1:0] head_of_class[NUM_CLASSES];
    logic [LINK_W-1:0] next_link[1 << GRAN_W];
    int                bump_ptr = 0;

    t_req   in_flight;
    t_reply predicted;
    t_reply oldest;
    int     n_accepted = 0;
    int     n_fail = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    int     n_served = 0;
    int     n_oom = 0;
    int     n_freed = 0;
    int     n_bad = 0;

    size_class_free_list_allocator #(
        .POOL_BYTES (POOL_BYTES),
        .NUM_CLASSES(NUM_CLASSES),
        .MAX_SIZE   (MAX_SIZE)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_reply apply_request(t_req r);
        t_reply            res;
        int                cls;
        int                need;
        logic [GRAN_W-1:0] gran;
        t_block            blk;
        res.user   = '0;
        res.status = ST_OK;
        if (r.size == 0 || int'(r.size) > MAX_SIZE) begin
            cls = -1;
        end else begin
            cls = (r.size <= 16) ? 0 : (int'(r.size) + 31) / 32;
            if (cls >= NUM_CLASSES) cls = -1;
        end
        if (cls < 0) begin
            res.status = ST_BADSIZE;
            n_bad++;
        end else if (r.kind == KIND_FREE) begin
            gran = r.offset[OFF_W-1:GRAN_SH];
            next_link[gran] = head_of_class[cls];
            head_of_class[cls] = {1'b1, gran};
            n_freed++;
        end else if (head_of_class[cls][GRAN_W]) begin
            gran = head_of_class[cls][GRAN_W-1:0];
            head_of_class[cls] = next_link[gran];
            res.user = {gran, 4'b0000};
        end else begin
            need = HDR_BYTES + ((cls == 0) ? MIN_BYTES : 32 * cls);
            if (bump_ptr > POOL_LIMIT || need > POOL_LIMIT - bump_ptr) begin
                res.status = ST_OOM;
            end else begin
                res.user = OFF_W'(bump_ptr + HDR_BYTES);
                bump_ptr = bump_ptr + need;
            end
        end
        if (r.kind == KIND_ALLOC && res.status == ST_OK) begin
            blk.offset = res.user;
            blk.size   = r.size;
            live_blocks.push_back(blk);
            n_served++;
        end
        if (r.kind == KIND_ALLOC && res.status == ST_OOM) n_oom++;
        return res;
    endfunction

    function automatic t_req make_req(logic kind, int size, int offset);
        t_req r;
        r.kind   = kind;
        r.size   = SIZE_W'(size);
        r.offset = OFF_W'(offset);
        return r;
    endfunction

    task automatic make_random_req(output t_req r);
        int     pick;
        int     idx;
        int     cls;
        t_block blk;
        pick = $urandom_range(99);
        r.kind   = ($urandom_range(1) == 1) ? KIND_FREE : KIND_ALLOC;
        r.offset = OFF_W'($urandom_range(65535));
        if (pick < 6) begin
            r.size = ($urandom_range(3) == 0) ? '0 : SIZE_W'($urandom_range(8191, MAX_SIZE + 1));
        end else if (pick < 50 && live_blocks.size() > 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[idx];
            if ($urandom_range(99) < 88) live_blocks.delete(idx);
            cls = (blk.size <= 16) ? 0 : (int'(blk.size) + 31) / 32;
            r.kind   = KIND_FREE;
            r.size   = (cls == 0) ? SIZE_W'($urandom_range(16, 1)) :
                                    SIZE_W'($urandom_range(32 * cls, 32 * cls - 31));
            r.offset = blk.offset;
            if ($urandom_range(99) < 20) r.offset[GRAN_SH-1:0] = GRAN_SH'($urandom_range(15));
        end else if (pick < 56) begin
            r.kind = KIND_FREE;
            r.size = SIZE_W'($urandom_range(MAX_SIZE, 1));
        end else begin
            r.kind = KIND_ALLOC;
            pick = $urandom_range(99);
            if (pick < 75) r.size = SIZE_W'($urandom_range(256, 1));
            else if (pick < 90) r.size = SIZE_W'($urandom_range(2048, 257));
            else r.size = SIZE_W'($urandom_range(MAX_SIZE, 1));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                predicted = apply_request(in_flight);
                expected_replies.push_back(predicted);
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || o_s_tready) begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99) >= (n_accepted < 200 ? 23 : n_accepted < 400 ? 48 : 0)) begin
                    in_flight = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, in_flight.offset, in_flight.size};
                    s_tuser  <= in_flight.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_accepted >= 320) begin
            hold_left <= 80;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected transaction: user_offset=%0h status=%0d",
                           o_m_tdata, o_m_tuser);
                    n_fail++;
                end else begin
                    oldest = expected_replies.pop_front();
                    if (o_m_tdata !== oldest.user) begin
                        $error("user_offset: expected %0h, actual %0h", oldest.user, o_m_tdata);
                        n_fail++;
                    end
                    if (o_m_tuser !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, o_m_tuser);
                        n_fail++;
                    end
                end
            end
            m_tready <= (hold_left == 0) &&
                        ($urandom_range(99) >= (n_accepted < 200 ? 48 : n_accepted < 400 ? 23 : 0));
        end
    end

    initial begin
        #2_000_000;
        $display("size_class_free_list_allocator test failed");
        $finish;
    end

    initial begin
        t_req r;
        for (int c = 0; c < NUM_CLASSES; c++) head_of_class[c] = '0;
        for (int g = 0; g < (1 << GRAN_W); g++) next_link[g] = '0;

        // Opening sequence: class boundaries, bad sizes, list reuse, unaligned,
        // wrong-class, repeated and foreign frees.
        pending_reqs.push_back(make_req(KIND_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 16, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 17, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 32, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 33, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, MAX_SIZE, 16'hFFFF));
        pending_reqs.push_back(make_req(KIND_ALLOC, 0, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, MAX_SIZE + 1, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 8191, 16'hFFFF));
        pending_reqs.push_back(make_req(KIND_FREE, 0, 16'hFFFF));
        pending_reqs.push_back(make_req(KIND_FREE, 1, 16));
        pending_reqs.push_back(make_req(KIND_FREE, 16, 55));
        pending_reqs.push_back(make_req(KIND_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(KIND_FREE, MAX_SIZE, 80));
        pending_reqs.push_back(make_req(KIND_ALLOC, 8090, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 4000, 0));
        pending_reqs.push_back(make_req(KIND_FREE, 4000, 8400));
        pending_reqs.push_back(make_req(KIND_FREE, 4000, 8400));
        pending_reqs.push_back(make_req(KIND_ALLOC, 4000, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, 4000, 0));
        pending_reqs.push_back(make_req(KIND_FREE, 100, 16'hFFFF));
        pending_reqs.push_back(make_req(KIND_ALLOC, 100, 0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < RANDOM_REQS; i++) begin
            while (pending_reqs.size() >= 4) @(negedge i_clk);
            make_random_req(r);
            pending_reqs.push_back(r);
        end
        for (int i = 0; i < 12; i++) pending_reqs.push_back(make_req(KIND_ALLOC, MAX_SIZE, 0));

        while (pending_reqs.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Ran %0d requests: %0d allocations served, %0d out of memory,", n_accepted,
                 n_served, n_oom);
        $display("%0d frees pushed, %0d bad sizes, including a long output stall.", n_freed,
                 n_bad);
        if (n_fail == 0) begin
            $display("size_class_free_list_allocator test passed");
        end else begin
            $display("size_class_free_list_allocator test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
